// File: rtl/core/rsgt_pkg.sv
// ----------------------------------------------------------------------------
// rsgt_pkg
// Shared types and constants for the relay switch guard timer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsgt_pkg;

    localparam int TIME_BITS     = 32;
    localparam int SECONDS_BITS  = 23;
    localparam int MS_PER_SECOND = 1000;
    localparam int PROD_BITS     = SECONDS_BITS + 10;

    typedef logic [TIME_BITS-1:0]    time_t;
    typedef logic [SECONDS_BITS-1:0] seconds_t;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_ON        = 3'd1,
        CMD_OFF       = 3'd2,
        CMD_TOGGLE    = 3'd3,
        CMD_TIMED_ON  = 3'd4,
        CMD_TIMED_OFF = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        DRIVE_NONE = 2'd0,
        DRIVE_ON   = 2'd1,
        DRIVE_OFF  = 2'd2
    } drive_t;

    typedef struct packed {
        logic  relay_on;
        logic  hold_active;
        logic  last_valid;
        time_t last_ms;
        time_t hold_len_ms;
        logic  saved_store;
    } state_t;

    typedef struct packed {
        logic   accepted;
        drive_t drive_action;
        logic   drive_store;
        logic   relay_is_on;
        logic   hold_running;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/rsgt_step.sv
// ----------------------------------------------------------------------------
// rsgt_step
// Next-state and result logic for one command against the relay state.
// ----------------------------------------------------------------------------
`default_nettype none

module rsgt_step (
    input  rsgt_pkg::state_t   state,
    input  rsgt_pkg::time_t    min_toggle_ms,
    input  logic [2:0]         command,
    input  rsgt_pkg::time_t    now_ms,
    input  rsgt_pkg::seconds_t hold_seconds,
    input  logic               store_flag,
    output rsgt_pkg::state_t   state_next,
    output rsgt_pkg::result_t  result
);

    rsgt_pkg::time_t                   elapsed;
    logic                              guard_ok;
    logic [rsgt_pkg::PROD_BITS-1:0]    hold_prod;
    logic                              do_switch;
    logic                              target;
    logic                              drv_store;

    assign elapsed   = now_ms - state.last_ms;
    assign guard_ok  = !state.hold_active && (!state.last_valid || (elapsed > min_toggle_ms));
    assign hold_prod = rsgt_pkg::PROD_BITS'(hold_seconds)
                     * rsgt_pkg::PROD_BITS'(rsgt_pkg::MS_PER_SECOND);

    always_comb begin
        state_next = state;
        do_switch  = 1'b0;
        target     = 1'b0;
        drv_store  = 1'b0;
        unique case (rsgt_pkg::cmd_t'(command)) inside
            rsgt_pkg::CMD_TICK: begin
                // expired hold: guard cleared, revert always goes through
                if (state.hold_active && (elapsed > state.hold_len_ms)) begin
                    do_switch              = 1'b1;
                    target                 = !state.relay_on;
                    drv_store              = state.saved_store;
                    state_next.hold_active = 1'b0;
                    state_next.hold_len_ms = '0;
                    state_next.saved_store = 1'b0;
                end
            end
            rsgt_pkg::CMD_ON, rsgt_pkg::CMD_OFF, rsgt_pkg::CMD_TOGGLE: begin
                do_switch = guard_ok;
                target    = (command == rsgt_pkg::CMD_ON) ||
                            ((command == rsgt_pkg::CMD_TOGGLE) && !state.relay_on);
                drv_store = store_flag;
            end
            rsgt_pkg::CMD_TIMED_ON, rsgt_pkg::CMD_TIMED_OFF: begin
                target    = (command == rsgt_pkg::CMD_TIMED_ON);
                drv_store = store_flag;
                if (guard_ok && (state.relay_on != target)) begin
                    do_switch              = 1'b1;
                    state_next.hold_active = 1'b1;
                    state_next.hold_len_ms = hold_prod[rsgt_pkg::TIME_BITS-1:0];
                    state_next.saved_store = store_flag;
                end
            end
            default: begin
            end
        endcase

        if (do_switch) begin
            state_next.relay_on   = target;
            state_next.last_ms    = now_ms;
            state_next.last_valid = 1'b1;
        end

        result.accepted     = do_switch;
        result.drive_action = !do_switch ? rsgt_pkg::DRIVE_NONE :
                              (target ? rsgt_pkg::DRIVE_ON : rsgt_pkg::DRIVE_OFF);
        result.drive_store  = do_switch && drv_store;
        result.relay_is_on  = state_next.relay_on;
        result.hold_running = state_next.hold_active;
    end

endmodule

`default_nettype wire

// File: rtl/core/relay_switch_guard_timer_unit.sv
// ----------------------------------------------------------------------------
// relay_switch_guard_timer_unit
// Relay controller with anti-chatter guard and timed auto-revert.
// ----------------------------------------------------------------------------
// channel   | direction | handshake          | payload
// s_        | in        | s_valid / s_ready  | command, now_ms, hold_seconds, store_flag
// m_        | out       | m_valid / m_ready  | accepted, drive_action, drive_store,
//           |           |                    | relay_is_on, hold_running
// cfg_      | in        | cfg_wr_en          | cfg_wr_data (min_toggle_ms)
//
// One item per cycle while m_ is not stalled. An input transfer lands in the
// input register; from there it is evaluated against the relay state and
// written to the result register when that register advances, and presented
// on m_. Stall on m_ holds the result register and then the input register.
// Synchronous reset clears the relay state, guard, hold and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_switch_guard_timer_unit (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire  [31:0]                cfg_wr_data,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [2:0]                 s_command,
    input  wire  [31:0]                s_now_ms,
    input  wire  [22:0]                s_hold_seconds,
    input  wire                        s_store_flag,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic                       m_accepted,
    output logic [1:0]                 m_drive_action,
    output logic                       m_drive_store,
    output logic                       m_relay_is_on,
    output logic                       m_hold_running
);

    rsgt_pkg::time_t    min_toggle_reg;
    rsgt_pkg::state_t   state_reg;
    rsgt_pkg::state_t   state_next;
    rsgt_pkg::result_t  result_next;
    rsgt_pkg::result_t  result_reg;

    logic               in_vld_reg;
    logic [2:0]         cmd_reg;
    rsgt_pkg::time_t    now_reg;
    rsgt_pkg::seconds_t secs_reg;
    logic               store_reg;
    logic               out_vld_reg;
    logic               advance;

    assign advance = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || advance;

    rsgt_step u_step (
        .state         (state_reg),
        .min_toggle_ms (min_toggle_reg),
        .command       (cmd_reg),
        .now_ms        (now_reg),
        .hold_seconds  (secs_reg),
        .store_flag    (store_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_toggle_reg <= '0;
        end else if (cfg_wr_en) begin
            min_toggle_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            now_reg   <= s_now_ms;
            secs_reg  <= s_hold_seconds;
            store_reg <= s_store_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_vld_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_accepted     = result_reg.accepted;
    assign m_drive_action = result_reg.drive_action;
    assign m_drive_store  = result_reg.drive_store;
    assign m_relay_is_on  = result_reg.relay_is_on;
    assign m_hold_running = result_reg.hold_running;

endmodule

`default_nettype wire
